@@ design/rsss_pkg.sv @@
`default_nettype none

package rsss_pkg;

  localparam int unsigned SPAN_W  = 12;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned ERR_W   = 15;
  localparam int unsigned CNT_W   = 4;

  localparam logic [CNT_W-1:0]   DIV_STEPS      = 4'd12;
  localparam logic [SPAN_W-1:0]  DEST_SPAN_RST  = 12'd1;
  localparam logic [SPAN_W-1:0]  SRC_SPAN_RST   = 12'd0;
  localparam logic [COLOR_W-1:0] TRANSP_RST     = 8'hFF;
  localparam logic [SPAN_W-1:0]  MIN_SRC_SPAN   = 12'd2;

  typedef enum logic [1:0] {
    CFG_DEST_SPAN   = 2'd0,
    CFG_SOURCE_SPAN = 2'd1,
    CFG_TRANSP      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [SPAN_W-1:0] quot;
    logic [SPAN_W-1:0] rem;
  } div_res_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [SPAN_W-1:0]  start;
    logic [LEN_W-1:0]   length;
    logic               we;
    logic               done;
  } run_t;

endpackage

`default_nettype wire

@@ design/rsss_div.sv @@
`default_nettype none

module rsss_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rsss_pkg::SPAN_W-1:0]  dividend_i,
  input  logic [rsss_pkg::SPAN_W-1:0]  divisor_i,
  output logic                         busy_o,
  output logic                         done_o,
  output rsss_pkg::div_res_t           result_o
);
  import rsss_pkg::*;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [SPAN_W-1:0] rem_q, rem_d;
  logic [SPAN_W-1:0] quo_q, quo_d;
  logic [SPAN_W-1:0] dvs_q, dvs_d;
  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   diff;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial  = {rem_q, quo_q[SPAN_W-1]};
    diff   = trial - {1'b0, dvs_q};
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d = DIV_STEPS;
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[SPAN_W-1:0];
        quo_d = {quo_q[SPAN_W-2:0], 1'b1};
      end else begin
        rem_d = trial[SPAN_W-1:0];
        quo_d = {quo_q[SPAN_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o        = (cnt_q != '0);
  assign done_o        = done_q;
  assign result_o.quot = quo_q;
  assign result_o.rem  = rem_q;

endmodule

`default_nettype wire

@@ design/run_slice_scanline_stretch_core.sv @@
// run-length slice scanline stretcher
// config port: cfg_we_i with cfg_idx_i (0 dest span, 1 source span,
// 2 transparent color) and cfg_wdata_i; a write to any of them restarts
// the line and kicks a 12-step serial divide of dest span by source span.
// in_stall_o stays high from the write cycle on while the divide runs and
// while the derived step, error and edge run values settle.
// input request: one source pixel on in_valid_i / in_stall_o, taken in
// every cycle once the divider is idle and the skid register is empty.
// output request: one run per pixel on out_valid_o / out_stall_i,
// registered once the pixel is taken; a source span below 2 swallows
// pixels and gives nothing. a line is source span + 1 pixels;
// line_done_o marks its last run and the next pixel starts a new line.
// when the receiver stalls, the run waits in the output register and one
// more is caught in a skid register; in_stall_o rises while that is full.
// reset: dest span 1, source span 0, transparent color 255, derived
// values zero, line restarted, output empty.
`default_nettype none

module run_slice_scanline_stretch_core #(
  parameter int unsigned MAX_SPAN = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [rsss_pkg::SPAN_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rsss_pkg::COLOR_W-1:0]  source_pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rsss_pkg::COLOR_W-1:0]  run_color_o,
  output logic [rsss_pkg::SPAN_W-1:0]   run_start_o,
  output logic [rsss_pkg::LEN_W-1:0]    run_length_o,
  output logic                          write_enable_o,
  output logic                          line_done_o
);
  import rsss_pkg::*;

  localparam int unsigned PosW = $clog2(2 * MAX_SPAN);
  localparam int unsigned SumW = ((PosW > LEN_W) ? PosW : LEN_W) + 1;
  localparam logic [SumW-1:0] PosSat = SumW'(2 * MAX_SPAN - 1);

  // configuration
  logic [SPAN_W-1:0]  dest_q, dest_d;
  logic [SPAN_W-1:0]  src_q, src_d;
  logic [COLOR_W-1:0] transp_q, transp_d;
  logic               cfg_hit;
  logic               start_q;

  // derived values
  logic [SPAN_W-1:0]  ws_q, ws_d;
  logic [LEN_W-1:0]   adj_q, adj_d;
  logic [ERR_W-1:0]   serr_q, serr_d;
  logic [SPAN_W-1:0]  edge0_q, edge0_d;
  logic [SPAN_W-1:0]  edge1_q, edge1_d;

  // line state
  logic [ERR_W-1:0]   err_q, err_d;
  logic [SPAN_W-1:0]  pix_q, pix_d;
  logic [PosW-1:0]    pos_q, pos_d;

  // divider
  logic               div_busy;
  logic               div_done;
  div_res_t           div_res;

  // step logic
  logic               span_ok;
  logic               acc;
  logic               first_run;
  logic               last_run;
  logic [ERR_W:0]     err_sum;
  logic [ERR_W:0]     err_sub;
  logic [ERR_W:0]     two_src;
  logic               over;
  logic [LEN_W-1:0]   len;
  logic [SumW-1:0]    pos_sum;
  logic [SPAN_W+PosW-1:0] pos_ext;
  logic [SPAN_W-1:0]  edge_half;
  logic [ERR_W:0]     serr_full;
  run_t               run;

  // output register and skid
  run_t               out_q, out_d;
  run_t               skid_q, skid_d;
  logic               out_valid_q, out_valid_d;
  logic               skid_valid_q, skid_valid_d;
  logic               push;
  logic               pop;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == CFG_DEST_SPAN || cfg_idx_i == CFG_SOURCE_SPAN
                                || cfg_idx_i == CFG_TRANSP);

  always_comb begin
    dest_d   = dest_q;
    src_d    = src_q;
    transp_d = transp_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEST_SPAN:   dest_d   = cfg_wdata_i;
        CFG_SOURCE_SPAN: src_d    = cfg_wdata_i;
        CFG_TRANSP:      transp_d = cfg_wdata_i[COLOR_W-1:0];
        default:         dest_d   = dest_q;
      endcase
    end
  end

  rsss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (dest_q),
    .divisor_i  (src_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .result_o   (div_res)
  );

  assign span_ok    = (src_q >= MIN_SRC_SPAN);
  assign in_stall_o = cfg_we_i || start_q || div_busy || div_done || skid_valid_q;
  assign acc        = in_valid_i && !in_stall_o;
  assign push       = acc && span_ok;
  assign pop        = out_valid_q && !out_stall_i;

  // derived values from the quotient and remainder
  always_comb begin
    edge_half = {1'b0, div_res.quot[SPAN_W-1:1]} + 1'b1;
    serr_full = {{(ERR_W+1-SPAN_W){1'b0}}, div_res.rem}
              - {{(ERR_W-SPAN_W){1'b0}}, src_q, 1'b0}
              + (div_res.quot[0] ? {{(ERR_W+1-SPAN_W){1'b0}}, src_q} : '0);
    ws_d    = ws_q;
    adj_d   = adj_q;
    serr_d  = serr_q;
    edge0_d = edge0_q;
    edge1_d = edge1_q;
    if (div_done) begin
      if (span_ok) begin
        ws_d    = div_res.quot;
        adj_d   = {div_res.rem, 1'b0};
        serr_d  = serr_full[ERR_W-1:0];
        edge1_d = edge_half;
        edge0_d = (div_res.rem == '0 && !div_res.quot[0]) ? edge_half - 1'b1 : edge_half;
      end else begin
        ws_d    = '0;
        adj_d   = '0;
        serr_d  = '0;
        edge0_d = '0;
        edge1_d = '0;
      end
    end
  end

  // one run per pixel
  always_comb begin
    first_run = (pix_q == '0);
    last_run  = !first_run && (pix_q >= src_q);
    err_sum   = {err_q[ERR_W-1], err_q} + {{(ERR_W+1-LEN_W){1'b0}}, adj_q};
    two_src   = {{(ERR_W-SPAN_W){1'b0}}, src_q, 1'b0};
    err_sub   = err_sum - two_src;
    over      = !err_sum[ERR_W] && (err_sum != '0);
    if (first_run) begin
      len = {1'b0, edge0_q};
    end else if (last_run) begin
      len = {1'b0, edge1_q};
    end else begin
      len = {1'b0, ws_q} + LEN_W'(over);
    end
    pos_sum = SumW'(pos_q) + SumW'(len);
    pos_ext = {{SPAN_W{1'b0}}, pos_q};

    run.color  = source_pixel_i;
    run.start  = pos_ext[SPAN_W-1:0];
    run.length = len;
    run.we     = (source_pixel_i != transp_q);
    run.done   = last_run;

    err_d = err_q;
    pix_d = pix_q;
    pos_d = pos_q;
    if (div_done) begin
      err_d = serr_d;
      pix_d = '0;
      pos_d = '0;
    end else if (cfg_hit) begin
      pix_d = '0;
      pos_d = '0;
    end else if (push) begin
      if (last_run) begin
        err_d = serr_q;
        pix_d = '0;
        pos_d = '0;
      end else begin
        if (!first_run) begin
          err_d = over ? err_sub[ERR_W-1:0] : err_sum[ERR_W-1:0];
        end
        pix_d = pix_q + 1'b1;
        pos_d = (pos_sum > PosSat) ? PosSat[PosW-1:0] : pos_sum[PosW-1:0];
      end
    end
  end

  // output register with one skid entry
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_d       = run;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = run;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_q       <= DEST_SPAN_RST;
      src_q        <= SRC_SPAN_RST;
      transp_q     <= TRANSP_RST;
      start_q      <= 1'b0;
      ws_q         <= '0;
      adj_q        <= '0;
      serr_q       <= '0;
      edge0_q      <= '0;
      edge1_q      <= '0;
      err_q        <= '0;
      pix_q        <= '0;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      dest_q       <= dest_d;
      src_q        <= src_d;
      transp_q     <= transp_d;
      start_q      <= cfg_hit;
      ws_q         <= ws_d;
      adj_q        <= adj_d;
      serr_q       <= serr_d;
      edge0_q      <= edge0_d;
      edge1_q      <= edge1_d;
      err_q        <= err_d;
      pix_q        <= pix_d;
      pos_q        <= pos_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign run_color_o    = out_q.color;
  assign run_start_o    = out_q.start;
  assign run_length_o   = out_q.length;
  assign write_enable_o = out_q.we;
  assign line_done_o    = out_q.done;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_err_not_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q[ERR_W-1] || err_q == '0)
    else $error("error term left positive");

  a_line_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && last_run |=> pix_q == '0 && pos_q == '0)
    else $error("line did not restart after final run");

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> in_stall_o && pix_q == '0)
    else $error("input taken while derived values settle");

endmodule

`default_nettype wire
